/* rtl/b64rs_pkg.sv */
// ----------------------------------------------------------------------------
// b64rs_pkg: shared types and constants of the base64 run scanner
// Register indexes, reset values, run records and the base64 alphabet test.
// ----------------------------------------------------------------------------
package b64rs_pkg;

  localparam int unsigned PosBitsDefault = 32;
  localparam int unsigned CfgIdxW        = 8;
  localparam int unsigned CfgDataW       = 20;
  localparam int unsigned SizeW          = 20;
  localparam int unsigned FieldW         = 32;
  localparam int unsigned PadW           = 8;

  localparam logic [CfgIdxW-1:0] CfgMinDecoded = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxDecoded = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgSkipLength = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgPowerOfTwo = CfgIdxW'(3);

  localparam logic [SizeW-1:0] MinDecodedReset = SizeW'(16);
  localparam logic [SizeW-1:0] MaxDecodedReset = SizeW'(102400);

  localparam logic [7:0] PadChar = 8'h3d;

  // result queue depth, room for two items of two results each in flight
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [SizeW-1:0] min_decoded_size;
    logic [SizeW-1:0] max_decoded_size;
    logic             skip_length_check;
    logic             power_of_two_only;
  } cfg_t;

  typedef struct packed {
    logic [FieldW-1:0] start_position;
    logic [FieldW-1:0] run_length;
    logic [PadW-1:0]   padding_count;
  } run_rec_t;

  typedef struct packed {
    logic [FieldW-1:0] start_position;
    logic [FieldW-1:0] run_length;
    logic [FieldW-1:0] decoded_size;
    logic              last_of_run;
  } result_t;

  function automatic logic is_b64(input logic [7:0] b);
    logic upper, lower, digit;
    upper = (b >= 8'h41) && (b <= 8'h5a);
    lower = (b >= 8'h61) && (b <= 8'h7a);
    digit = (b >= 8'h30) && (b <= 8'h39);
    return upper || lower || digit || (b == 8'h2b) || (b == 8'h2f);
  endfunction

endpackage

/* rtl/b64rs_if.sv */
// ----------------------------------------------------------------------------
// b64rs_if: valid/ready channels of the base64 run scanner
// Byte input channel and run result channel.
// ----------------------------------------------------------------------------
interface b64rs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface b64rs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_position;
  logic [31:0] run_length;
  logic [31:0] decoded_size;
  logic        last_of_run;

  modport source (output valid, output start_position, output run_length,
                  output decoded_size, output last_of_run, input ready);
  modport sink   (input valid, input start_position, input run_length,
                  input decoded_size, input last_of_run, output ready);
endinterface

/* rtl/b64rs_filter.sv */
// ----------------------------------------------------------------------------
// b64rs_filter: decoded size and report filter for one finished run
// Computes floor(3*len/4) - padding clamped at zero and applies the filters.
// ----------------------------------------------------------------------------
module b64rs_filter (
  input  b64rs_pkg::run_rec_t              rec_i,
  input  b64rs_pkg::cfg_t                  cfg_i,
  output logic [b64rs_pkg::FieldW-1:0]     decoded_size_o,
  output logic                             pass_o
);

  logic [b64rs_pkg::FieldW+1:0] triple;
  logic [b64rs_pkg::FieldW-1:0] full;
  logic [b64rs_pkg::FieldW-1:0] pad_ext;
  logic [b64rs_pkg::FieldW-1:0] dec;
  logic                         len_ok, range_ok, pow_ok;

  always_comb begin
    triple  = {1'b0, rec_i.run_length, 1'b0} + {2'b00, rec_i.run_length};
    full    = triple[b64rs_pkg::FieldW+1:2];
    pad_ext = b64rs_pkg::FieldW'(rec_i.padding_count);
    dec     = (full > pad_ext) ? (full - pad_ext) : '0;

    len_ok   = cfg_i.skip_length_check || (rec_i.run_length[1:0] == 2'b00);
    range_ok = (dec >= b64rs_pkg::FieldW'(cfg_i.min_decoded_size)) &&
               (dec <= b64rs_pkg::FieldW'(cfg_i.max_decoded_size));
    pow_ok   = !cfg_i.power_of_two_only ||
               ((dec != '0) && ((dec & (dec - b64rs_pkg::FieldW'(1))) == '0));

    decoded_size_o = dec;
    pass_o         = len_ok && range_ok && pow_ok;
  end

endmodule

/* rtl/base64_run_scanner_core.sv */
// ----------------------------------------------------------------------------
// base64_run_scanner_core: finds runs of base64 text in a byte stream
// Tracks outside / base64 / padding mode and reports filtered runs.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one buffer byte per transaction with end_of_buffer marking
//   the last byte. out_if carries one reported run per transaction; a byte
//   can cause zero, one or two results, and last_of_run marks the last one.
//   The configuration port writes min/max decoded size, skip_length_check
//   and power_of_two_only; write only while no results are pending.
// Throughput: one byte per cycle while in_if.ready is high. The mode machine
//   updates at the byte's transaction; finished runs are held in a record
//   register, then the filter stage pushes passing runs into a four-entry
//   result queue. A result reaches out_if through the record register and
//   then the result queue.
// Stall: input ready drops when the queue plus records in flight could not
//   take two more results; nothing is dropped while out_if is stalled.
// Reset: mode outside, byte position zero, queue empty, registers at their
//   reset values (min 16, max 102400, both flags clear).
// ----------------------------------------------------------------------------
module base64_run_scanner_core #(
  parameter int unsigned POS_BITS = b64rs_pkg::PosBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [b64rs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [b64rs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  b64rs_in_if.sink                         in_if,
  b64rs_out_if.source                      out_if
);

  typedef enum logic [1:0] {
    ModeOut,
    ModeB64,
    ModePad
  } mode_e;

  localparam int unsigned FW = b64rs_pkg::FieldW;
  localparam int unsigned PW = b64rs_pkg::PadW;
  localparam int unsigned CW = b64rs_pkg::FifoCntW;
  localparam int unsigned QW = b64rs_pkg::FifoPtrW;

  function automatic logic [FW-1:0] sat_start(input logic [POS_BITS-1:0] pos);
    logic [63:0] wide;
    wide = 64'(pos);
    return (|wide[63:32]) ? '1 : wide[31:0];
  endfunction

  // configuration
  b64rs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_decoded_size  <= b64rs_pkg::MinDecodedReset;
      cfg_q.max_decoded_size  <= b64rs_pkg::MaxDecodedReset;
      cfg_q.skip_length_check <= 1'b0;
      cfg_q.power_of_two_only <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        b64rs_pkg::CfgMinDecoded: cfg_q.min_decoded_size  <= cfg_wdata_i;
        b64rs_pkg::CfgMaxDecoded: cfg_q.max_decoded_size  <= cfg_wdata_i;
        b64rs_pkg::CfgSkipLength: cfg_q.skip_length_check <= cfg_wdata_i[0];
        b64rs_pkg::CfgPowerOfTwo: cfg_q.power_of_two_only <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // scan state
  mode_e             mode_q, mode_nx, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [FW-1:0]     len_q, len_d, len_inc;
  logic [PW-1:0]     pad_q, pad_d, pad_inc;
  logic              b64, pad, eob, in_acc;
  logic              fin_mid, fin_eob;
  b64rs_pkg::run_rec_t rec_a, rec_b;

  // record stage and result queue
  logic              s1_a_q, s1_b_q;
  b64rs_pkg::run_rec_t s1_rec_a_q, s1_rec_b_q;
  logic [FW-1:0]     dec_a, dec_b;
  logic              pass_a, pass_b, push_a, push_b, pop;
  b64rs_pkg::result_t fifo_q [b64rs_pkg::FifoDepth];
  logic [QW-1:0]     wr_q, rd_q, wr_b;
  logic [CW-1:0]     count_q, count_d, s1_n;

  assign b64    = b64rs_pkg::is_b64(in_if.data_byte);
  assign pad    = (in_if.data_byte == b64rs_pkg::PadChar);
  assign eob    = in_if.end_of_buffer;
  assign in_acc = in_if.valid && in_if.ready;

  assign len_inc = (len_q != '1) ? len_q + FW'(1) : len_q;
  assign pad_inc = (pad_q != '1) ? pad_q + PW'(1) : pad_q;

  always_comb begin
    mode_nx = mode_q;
    start_d = start_q;
    len_d   = len_q;
    pad_d   = pad_q;
    fin_mid = 1'b0;
    case (mode_q)
      ModeOut: begin
        if (b64) begin
          mode_nx = ModeB64;
          start_d = pos_q;
          len_d   = FW'(1);
          pad_d   = '0;
        end
      end
      ModeB64: begin
        if (b64) begin
          len_d = len_inc;
        end else if (pad) begin
          mode_nx = ModePad;
          len_d   = len_inc;
          pad_d   = PW'(1);
        end else begin
          fin_mid = 1'b1;
          mode_nx = ModeOut;
        end
      end
      ModePad: begin
        if (pad) begin
          len_d = len_inc;
          pad_d = pad_inc;
        end else if (b64) begin
          // joined strings: close the run, this byte opens the next one
          fin_mid = 1'b1;
          mode_nx = ModeB64;
          start_d = pos_q;
          len_d   = FW'(1);
          pad_d   = '0;
        end else begin
          fin_mid = 1'b1;
          mode_nx = ModeOut;
        end
      end
      default: mode_nx = ModeOut;
    endcase

    fin_eob = eob && (mode_nx != ModeOut);
    if (eob) begin
      mode_d = ModeOut;
      pos_d  = '0;
    end else begin
      mode_d = mode_nx;
      pos_d  = (pos_q != '1) ? pos_q + POS_BITS'(1) : pos_q;
    end

    rec_a.start_position = sat_start(start_q);
    rec_a.run_length     = len_q;
    rec_a.padding_count  = pad_q;
    rec_b.start_position = sat_start(start_d);
    rec_b.run_length     = len_d;
    rec_b.padding_count  = pad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeOut;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      pad_q   <= '0;
      s1_a_q  <= 1'b0;
      s1_b_q  <= 1'b0;
    end else begin
      s1_a_q <= in_acc && fin_mid;
      s1_b_q <= in_acc && fin_eob;
      if (in_acc) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        pad_q   <= pad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rec_a_q <= rec_a;
      s1_rec_b_q <= rec_b;
    end
  end

  b64rs_filter u_filter_a (
    .rec_i          (s1_rec_a_q),
    .cfg_i          (cfg_q),
    .decoded_size_o (dec_a),
    .pass_o         (pass_a)
  );

  b64rs_filter u_filter_b (
    .rec_i          (s1_rec_b_q),
    .cfg_i          (cfg_q),
    .decoded_size_o (dec_b),
    .pass_o         (pass_b)
  );

  assign push_a = s1_a_q && pass_a;
  assign push_b = s1_b_q && pass_b;
  assign pop    = out_if.valid && out_if.ready;
  assign wr_b   = wr_q + QW'(push_a);
  assign s1_n   = CW'(s1_a_q) + CW'(s1_b_q);
  assign count_d = count_q + CW'(push_a) + CW'(push_b) - CW'(pop);

  // hold input while the queue could not absorb two more results
  assign in_if.ready = (count_q + s1_n) <= CW'(b64rs_pkg::FifoDepth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_b + QW'(push_b);
      rd_q    <= rd_q + QW'(pop);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      fifo_q[wr_q] <= '{start_position: s1_rec_a_q.start_position,
                        run_length:     s1_rec_a_q.run_length,
                        decoded_size:   dec_a,
                        last_of_run:    !push_b};
    end
    if (push_b) begin
      fifo_q[wr_b] <= '{start_position: s1_rec_b_q.start_position,
                        run_length:     s1_rec_b_q.run_length,
                        decoded_size:   dec_b,
                        last_of_run:    1'b1};
    end
  end

  assign out_if.valid          = (count_q != '0);
  assign out_if.start_position = fifo_q[rd_q].start_position;
  assign out_if.run_length     = fifo_q[rd_q].run_length;
  assign out_if.decoded_size   = fifo_q[rd_q].decoded_size;
  assign out_if.last_of_run    = fifo_q[rd_q].last_of_run;

endmodule

/* rtl/b64rs_checker.sv */
// ----------------------------------------------------------------------------
// b64rs_checker: port-level checks of the base64 run scanner
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module b64rs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_start_i,
  input logic [31:0] out_len_i,
  input logic [31:0] out_dec_i,
  input logic        out_last_i
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_start_i) && $stable(out_len_i) && $stable(out_dec_i) &&
      $stable(out_last_i))
    else $error("stalled result changed");

  // the second result of a byte is already queued behind the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_i |=> out_valid_i)
    else $error("second result of a byte missing");

  // a newly offered result comes from a byte transaction through the record register and the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i) |-> $past(in_acc, 2))
    else $error("result without a byte two cycles earlier");

endmodule

bind base64_run_scanner_core b64rs_checker u_b64rs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_start_i (out_if.start_position),
  .out_len_i   (out_if.run_length),
  .out_dec_i   (out_if.decoded_size),
  .out_last_i  (out_if.last_of_run)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of base64_run_scanner_core
// Sends buffers of raw bytes with random gaps on the byte channel and applies
// random stalls on the run channel. A scoreboard mirrors the scan machine and
// the run filters and checks every reported run field by field. The filter
// registers are rewritten between phases once all expected runs are out.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ScanPosW = b64rs_pkg::PosBitsDefault;
  localparam logic [b64rs_pkg::CfgIdxW-1:0] CfgUnusedLow  = b64rs_pkg::CfgIdxW'(4);
  localparam logic [b64rs_pkg::CfgIdxW-1:0] CfgUnusedHigh = '1;

  typedef enum logic [1:0] {ScanOutside, ScanBase64, ScanPadding} scan_mode_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [b64rs_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [b64rs_pkg::CfgDataW-1:0] cfg_wdata;

  b64rs_in_if  byte_ch ();
  b64rs_out_if run_ch ();

  base64_run_scanner_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (byte_ch.sink),
    .out_if      (run_ch.source)
  );

  // scoreboard copy of the scanner state and filter registers
  scan_mode_e                  sc_mode;
  logic [ScanPosW-1:0]         sc_pos;
  logic [ScanPosW-1:0]         sc_start;
  logic [31:0]                 sc_len;
  logic [b64rs_pkg::PadW-1:0]  sc_pad;
  logic [b64rs_pkg::SizeW-1:0] lim_min;
  logic [b64rs_pkg::SizeW-1:0] lim_max;
  logic                        len_check_off;
  logic                        pow2_only;

  b64rs_pkg::result_t expected_runs[$];
  logic [7:0]         buf_bytes[$];
  int unsigned        fails;
  int unsigned        bytes_sent;
  bit                 in_quiet;

  always #1 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit byte_in_alphabet(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
           (b >= "0" && b <= "9") || b == "+" || b == "/";
  endfunction

  function automatic logic [7:0] rand_b64();
    int unsigned k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return (k == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (byte_in_alphabet(b) || b == b64rs_pkg::PadChar);
    return b;
  endfunction

  // mostly no wait, sometimes a short one; long stretches with no waiting at all
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 40) == 0) quiet = !quiet;
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic void reset_scanner();
    sc_mode       = ScanOutside;
    sc_pos        = '0;
    sc_start      = '0;
    sc_len        = '0;
    sc_pad        = '0;
    lim_min       = b64rs_pkg::MinDecodedReset;
    lim_max       = b64rs_pkg::MaxDecodedReset;
    len_check_off = 1'b0;
    pow2_only     = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [b64rs_pkg::CfgIdxW-1:0] idx,
                                    input logic [b64rs_pkg::CfgDataW-1:0] val);
    case (idx)
      b64rs_pkg::CfgMinDecoded: lim_min       = val[b64rs_pkg::SizeW-1:0];
      b64rs_pkg::CfgMaxDecoded: lim_max       = val[b64rs_pkg::SizeW-1:0];
      b64rs_pkg::CfgSkipLength: len_check_off = val[0];
      b64rs_pkg::CfgPowerOfTwo: pow2_only     = val[0];
      default: ;
    endcase
  endfunction

  function automatic void open_run();
    sc_mode  = ScanBase64;
    sc_start = sc_pos;
    sc_len   = 32'd1;
    sc_pad   = '0;
  endfunction

  function automatic void grow_run();
    if (sc_len != '1) sc_len++;
  endfunction

  // filter the finished run and queue it when it passes
  function automatic void close_run();
    longint unsigned    whole;
    longint unsigned    dec;
    b64rs_pkg::result_t r;
    whole = (64'(sc_len) * 3) / 4;
    dec   = (whole > 64'(sc_pad)) ? whole - 64'(sc_pad) : 0;
    if (!len_check_off && sc_len[1:0] != 2'b00) return;
    if (dec < 64'(lim_min) || dec > 64'(lim_max)) return;
    if (pow2_only && (dec == 0 || (dec & (dec - 1)) != 0)) return;
    r.start_position = (64'(sc_start) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sc_start);
    r.run_length     = sc_len;
    r.decoded_size   = dec[31:0];
    r.last_of_run    = 1'b0;
    expected_runs.push_back(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eob);
    int                 base;
    bit                 b64;
    bit                 pad;
    b64rs_pkg::result_t r;
    base = expected_runs.size();
    b64  = byte_in_alphabet(b);
    pad  = (b == b64rs_pkg::PadChar);
    case (sc_mode)
      ScanOutside: begin
        if (b64) open_run();
      end
      ScanBase64: begin
        if (b64) begin
          grow_run();
        end else if (pad) begin
          sc_mode = ScanPadding;
          grow_run();
          sc_pad = 8'd1;
        end else begin
          close_run();
          sc_mode = ScanOutside;
        end
      end
      default: begin
        if (pad) begin
          grow_run();
          if (sc_pad != '1) sc_pad++;
        end else if (b64) begin
          close_run();
          open_run();
        end else begin
          close_run();
          sc_mode = ScanOutside;
        end
      end
    endcase
    if (eob) begin
      if (sc_mode != ScanOutside) close_run();
      sc_mode = ScanOutside;
      sc_pos  = '0;
    end else if (sc_pos != '1) begin
      sc_pos++;
    end
    if (expected_runs.size() > base) begin
      r = expected_runs.pop_back();
      r.last_of_run = 1'b1;
      expected_runs.push_back(r);
    end
  endfunction

  function automatic void check_run();
    b64rs_pkg::result_t want;
    if (expected_runs.size() == 0) begin
      $error("unexpected run: start_position %0d run_length %0d decoded_size %0d",
             run_ch.start_position, run_ch.run_length, run_ch.decoded_size);
      fails++;
      return;
    end
    want = expected_runs.pop_front();
    if (run_ch.start_position !== want.start_position) begin
      $error("start_position: expected %0d, actual %0d",
             want.start_position, run_ch.start_position);
      fails++;
    end
    if (run_ch.run_length !== want.run_length) begin
      $error("run_length: expected %0d, actual %0d", want.run_length, run_ch.run_length);
      fails++;
    end
    if (run_ch.decoded_size !== want.decoded_size) begin
      $error("decoded_size: expected %0d, actual %0d",
             want.decoded_size, run_ch.decoded_size);
      fails++;
    end
    if (run_ch.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, actual %0d", want.last_of_run, run_ch.last_of_run);
      fails++;
    end
  endfunction

  // run channel: stall before each transaction, check it when it comes
  initial begin : run_sink
    int unsigned stall;
    bit          quiet;
    quiet = 1'b0;
    run_ch.ready = 1'b0;
    forever begin
      stall = draw_wait(quiet);
      if (stall != 0) begin
        run_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      run_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!run_ch.valid);
      check_run();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int unsigned gap;
    gap = draw_wait(in_quiet);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (!byte_ch.ready);
    predict_byte(b, eob);
    if (byte_in_alphabet(b) || b == b64rs_pkg::PadChar) bytes_sent++;
  endtask

  // hold the byte channel until every expected run is out, then let the
  // pipeline settle for bytes that report nothing
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [b64rs_pkg::CfgIdxW-1:0] idx,
                           input logic [b64rs_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_filters(input logic [b64rs_pkg::SizeW-1:0] lo,
                             input logic [b64rs_pkg::SizeW-1:0] hi,
                             input logic skip, input logic pow2);
    write_reg(b64rs_pkg::CfgMinDecoded, b64rs_pkg::CfgDataW'(lo));
    write_reg(b64rs_pkg::CfgMaxDecoded, b64rs_pkg::CfgDataW'(hi));
    write_reg(b64rs_pkg::CfgSkipLength, b64rs_pkg::CfgDataW'(skip));
    write_reg(b64rs_pkg::CfgPowerOfTwo, b64rs_pkg::CfgDataW'(pow2));
  endtask

  // one buffer: well-formed base64 strings, broken runs and noise bytes
  function automatic void build_buffer();
    int unsigned nseg;
    int unsigned s;
    int unsigned kind;
    int unsigned quads;
    int unsigned tail;
    int unsigned n;
    buf_bytes.delete();
    nseg = $urandom_range(1, 5);
    for (s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        quads = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
        tail  = $urandom_range(2, 4);
        for (n = 0; n < 4 * (quads - 1) + tail; n++) buf_bytes.push_back(rand_b64());
        for (n = tail; n < 4; n++) buf_bytes.push_back(b64rs_pkg::PadChar);
        // no separator: the next segment joins this string
        if ($urandom_range(0, 3) != 0) buf_bytes.push_back(rand_other());
      end else if (kind < 9) begin
        for (n = $urandom_range(1, 30); n != 0; n--)
          buf_bytes.push_back(($urandom_range(0, 3) == 0) ? b64rs_pkg::PadChar : rand_b64());
        if ($urandom_range(0, 1) != 0) buf_bytes.push_back(rand_other());
      end else begin
        for (n = $urandom_range(1, 6); n != 0; n--)
          buf_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic send_buffer();
    int unsigned k;
    for (k = 0; k < buf_bytes.size(); k++)
      send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
  endtask

  task automatic run_buffers(input int unsigned target);
    bytes_sent = 0;
    while (bytes_sent < target) begin
      build_buffer();
      send_buffer();
    end
    wait_idle();
  endtask

  task automatic test_reset_filters();
    run_buffers(150);
  endtask

  task automatic test_directed_cases();
    set_filters('0, '1, 1'b1, 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b0);   // lone padding outside a run
    send_byte("A", 1'b0);
    send_byte("Z", 1'b0);
    send_byte("a", 1'b0);
    send_byte("z", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("0", 1'b0);
    send_byte("9", 1'b0);
    send_byte("+", 1'b0);
    send_byte("/", 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b0);
    send_byte("Q", 1'b0);                  // joined string after padding
    send_byte(8'hFF, 1'b0);
    send_byte("A", 1'b1);                  // one-character run flushed at the end
    send_byte("B", 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b1);   // flush inside padding
    send_byte("x", 1'b0);
    send_byte(b64rs_pkg::PadChar, 1'b0);
    send_byte("y", 1'b1);                  // joined string on the last byte: two runs
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte("/", 1'b0);
    send_byte(8'h3A, 1'b1);
    wait_idle();
  endtask

  task automatic test_register_writes();
    set_filters('0, '1, 1'b1, 1'b0);
    // only bit 0 of the flag registers counts; unused indexes are dropped
    write_reg(b64rs_pkg::CfgSkipLength, 20'hFFFFE);
    write_reg(b64rs_pkg::CfgPowerOfTwo, 20'h00003);
    write_reg(CfgUnusedLow, 20'h00000);
    write_reg(CfgUnusedHigh, 20'hFFFFF);
    run_buffers(80);
  endtask

  task automatic test_filter_settings();
    int unsigned                 k;
    logic [b64rs_pkg::SizeW-1:0] lo;
    set_filters('0, '1, 1'b0, 1'b0);
    run_buffers(150);
    set_filters('0, '0, 1'b1, 1'b0);
    run_buffers(100);
    set_filters('0, '1, 1'b1, 1'b1);
    run_buffers(150);
    set_filters('1, '1, 1'b1, 1'b0);
    run_buffers(40);
    set_filters(b64rs_pkg::SizeW'(8), b64rs_pkg::SizeW'(30), 1'b0, 1'b1);
    run_buffers(150);
    for (k = 0; k < 2; k++) begin
      lo = b64rs_pkg::SizeW'($urandom_range(0, 20));
      set_filters(lo, lo + b64rs_pkg::SizeW'($urandom_range(0, 60)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_buffers(100);
    end
  endtask

  // very long padding pushes the padding count past its saturation point
  task automatic test_long_runs();
    int unsigned k;
    int unsigned n;
    int unsigned ending;
    set_filters('0, '1, 1'b1, 1'b0);
    for (k = 0; k < 2; k++) begin
      buf_bytes.delete();
      for (n = $urandom_range(60, 140); n != 0; n--) buf_bytes.push_back(rand_b64());
      for (n = $urandom_range(260, 320); n != 0; n--) buf_bytes.push_back(b64rs_pkg::PadChar);
      ending = $urandom_range(0, 2);
      if (ending == 1) buf_bytes.push_back(rand_b64());
      else if (ending == 2) buf_bytes.push_back(rand_other());
      send_buffer();
    end
    wait_idle();
  endtask

  initial begin
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_wdata             = '0;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_buffer = 1'b0;
    fails                 = 0;
    bytes_sent            = 0;
    in_quiet              = 1'b0;
    reset_scanner();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_filters();
    test_directed_cases();
    test_register_writes();
    test_filter_settings();
    test_long_runs();

    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/b64rs_pkg.sv
rtl/b64rs_if.sv
rtl/b64rs_filter.sv
rtl/base64_run_scanner_core.sv
rtl/b64rs_checker.sv
test/tb.sv
